// ===== rtl/lspe_pkg.sv =====
package lspe_pkg;

	localparam int unsigned NumChannels = 7;
	localparam logic [6:0] LeftCornerMask = 7'h0F;
	localparam logic [6:0] RightCornerMask = 7'h78;

	localparam logic [6:0] MagnitudeReset = 7'd50;

	typedef enum logic [1:0] {
		REG_POLARITY_ACTIVE_LOW = 2'd0,
		REG_CORNER_DETECT_ENABLE = 2'd1,
		REG_CORNER_ERROR_MAGNITUDE = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		OP_HOLD = 3'd0,
		OP_LOAD = 3'd1,
		OP_ACC = 3'd2,
		OP_ABS = 3'd3,
		OP_DIV = 3'd4,
		OP_FIN = 3'd5
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] step;
	} ctrl_t;

	typedef struct packed {
		logic corner_en;
		logic [6:0] magnitude;
	} cfg_t;

	typedef struct packed {
		logic found;
		logic signed [1:0] direction;
	} corner_t;

	function automatic logic [7:0] lspe_weight(input logic [2:0] idx);
		logic [7:0] w;
		case (idx)
			3'd0: w = 8'sd50;
			3'd1: w = 8'sd33;
			3'd2: w = 8'sd16;
			3'd4: w = -8'sd16;
			3'd5: w = -8'sd33;
			3'd6: w = -8'sd50;
			default: w = 8'd0;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/lspe_if.sv =====
interface lspe_in_if;
	logic valid;
	logic ready;
	logic [6:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

interface lspe_out_if;
	logic valid;
	logic ready;
	logic [6:0] raw_levels;
	logic [6:0] active_channels;
	logic [2:0] active_total;
	logic line_present;
	logic signed [7:0] position_error;
	logic corner_found;
	logic signed [1:0] corner_direction;
	logic [31:0] sample_number;

	modport source (
		output valid, output raw_levels, output active_channels, output active_total,
		output line_present, output position_error, output corner_found,
		output corner_direction, output sample_number, input ready
	);
	modport sink (
		input valid, input raw_levels, input active_channels, input active_total,
		input line_present, input position_error, input corner_found,
		input corner_direction, input sample_number, output ready
	);
endinterface

interface lspe_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [6:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lspe_unit.sv =====
module lspe_unit
	import lspe_pkg::*;
(
	input logic clk,
	input ctrl_t ctrl,
	input logic [6:0] load_act,
	input cfg_t cfg,
	output logic [6:0] act,
	output logic [2:0] total,
	output logic signed [7:0] err,
	output corner_t corner
);

	logic [6:0] act_q;
	logic [7:0] acc_q;
	logic [2:0] cnt_q;
	logic [6:0] qd_q;
	logic [2:0] rem_q;

	logic [7:0] op_a;
	logic [7:0] op_b;
	logic sub;
	logic [7:0] sum;
	logic [3:0] shifted;
	logic left_m;
	logic right_m;
	logic left_c;
	logic right_c;

	assign shifted = {rem_q, qd_q[6]};
	assign left_m = (act_q & LeftCornerMask) == LeftCornerMask;
	assign right_m = (act_q & RightCornerMask) == RightCornerMask;
	assign left_c = cfg.corner_en && left_m && !right_m;
	assign right_c = cfg.corner_en && right_m && !left_m;

	// single shared adder
	always_comb begin
		op_a = '0;
		op_b = '0;
		sub = 1'b0;
		unique case (ctrl.op)
			OP_ACC: begin
				op_a = acc_q;
				op_b = lspe_weight(ctrl.step);
			end
			OP_ABS: begin
				op_b = acc_q;
				sub = 1'b1;
			end
			OP_DIV: begin
				op_a = {4'b0, shifted};
				op_b = {5'b0, cnt_q};
				sub = 1'b1;
			end
			OP_FIN: begin
				if (left_c) begin
					op_b = {1'b0, cfg.magnitude};
				end else if (right_c) begin
					op_b = {1'b0, cfg.magnitude};
					sub = 1'b1;
				end else begin
					op_b = {1'b0, qd_q};
					sub = acc_q[7];
				end
			end
			default: begin
			end
		endcase
		sum = op_a + (sub ? ~op_b : op_b) + {7'b0, sub};
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				act_q <= load_act;
				acc_q <= '0;
				cnt_q <= '0;
			end
			OP_ACC: begin
				if (act_q[ctrl.step]) begin
					acc_q <= sum;
					cnt_q <= cnt_q + 3'd1;
				end
			end
			OP_ABS: begin
				qd_q <= acc_q[7] ? sum[6:0] : acc_q[6:0];
				rem_q <= '0;
			end
			OP_DIV: begin
				// restoring step, one quotient bit
				if (!sum[7]) begin
					rem_q <= sum[2:0];
					qd_q <= {qd_q[5:0], 1'b1};
				end else begin
					rem_q <= shifted[2:0];
					qd_q <= {qd_q[5:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign act = act_q;
	assign total = cnt_q;
	assign err = signed'(sum);
	assign corner.found = left_c || right_c;
	assign corner.direction = left_c ? 2'sd1 : (right_c ? -2'sd1 : 2'sd0);

endmodule

// ===== rtl/line_sensor_position_estimator.sv =====
// Line sensor position estimator.
// sample: one item per sensor sample, pin_levels bit i is channel i.
// result: one item per sample with the active mask, active count, line flag,
// position error (weighted average of channel weights, or the corner
// magnitude on a right-angle corner), corner flags and the sample number.
// cfg: register writes (polarity, corner enable, corner magnitude), always
// ready; write only while no sample is in flight.
// For each sample the mask and counters load at the accepting edge, then
// seven accumulate steps and one absolute-value step run on the shared adder,
// seven restoring divide steps on that same adder and one final step, which
// writes the result register.
// sample.ready is high only while the sequencer is idle, so a new sample is
// accepted only after the previous one has reached the result register.
// A finished result waits in the output register; a new sample may be
// accepted meanwhile, but the final step waits until the register is free.
// Reset clears the held error and the sample counter, sets the registers
// to polarity active high, corner detect on and magnitude 50, and empties
// the output register.
module line_sensor_position_estimator
	import lspe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	lspe_in_if.sink sample,
	lspe_out_if.source result,
	lspe_cfg_if.sink cfg
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ACC = 5'b00010,
		S_ABS = 5'b00100,
		S_DIV = 5'b01000,
		S_FIN = 5'b10000
	} state_t;

	state_t state_q;
	logic [2:0] step_q;

	logic polarity_q;
	cfg_t cfg_q;

	logic [6:0] raw_q;
	logic signed [7:0] held_q;
	logic [31:0] count_q;

	logic out_valid_q;
	logic [6:0] out_raw_q;
	logic [6:0] out_act_q;
	logic [2:0] out_total_q;
	logic out_line_q;
	logic signed [7:0] out_err_q;
	logic out_found_q;
	logic signed [1:0] out_dir_q;

	ctrl_t ctrl;
	logic [6:0] load_act;
	logic [6:0] act;
	logic [2:0] total;
	logic signed [7:0] err;
	corner_t corner;

	logic in_fire;
	logic out_free;
	logic line;

	assign sample.ready = state_q == S_IDLE;
	assign in_fire = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;
	assign cfg.ready = 1'b1;
	assign load_act = polarity_q ? ~sample.pin_levels : sample.pin_levels;
	assign line = total != 3'd0;

	always_comb begin
		ctrl.step = step_q;
		unique case (state_q)
			S_IDLE: ctrl.op = in_fire ? OP_LOAD : OP_HOLD;
			S_ACC: ctrl.op = OP_ACC;
			S_ABS: ctrl.op = OP_ABS;
			S_DIV: ctrl.op = OP_DIV;
			S_FIN: ctrl.op = OP_FIN;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	lspe_unit u_unit (
		.clk(clk),
		.ctrl(ctrl),
		.load_act(load_act),
		.cfg(cfg_q),
		.act(act),
		.total(total),
		.err(err),
		.corner(corner)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b0;
			cfg_q.corner_en <= 1'b1;
			cfg_q.magnitude <= MagnitudeReset;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_POLARITY_ACTIVE_LOW: polarity_q <= cfg.data[0];
				REG_CORNER_DETECT_ENABLE: cfg_q.corner_en <= cfg.data[0];
				REG_CORNER_ERROR_MAGNITUDE: cfg_q.magnitude <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			held_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_ACC;
						step_q <= '0;
					end
				end
				S_ACC: begin
					if (step_q == 3'(NumChannels - 1)) begin
						state_q <= S_ABS;
						step_q <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_ABS: begin
					state_q <= S_DIV;
					step_q <= '0;
				end
				S_DIV: begin
					if (step_q == 3'(NumChannels - 1)) begin
						state_q <= S_FIN;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						count_q <= count_q + 32'd1;
						if (line) begin
							held_q <= err;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_q <= sample.pin_levels;
		end
		if (state_q == S_FIN && out_free) begin
			out_raw_q <= raw_q;
			out_act_q <= act;
			out_total_q <= total;
			out_line_q <= line;
			out_err_q <= line ? err : held_q;
			out_found_q <= line && corner.found;
			out_dir_q <= line ? corner.direction : 2'sd0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.raw_levels = out_raw_q;
	assign result.active_channels = out_act_q;
	assign result.active_total = out_total_q;
	assign result.line_present = out_line_q;
	assign result.position_error = out_err_q;
	assign result.corner_found = out_found_q;
	assign result.corner_direction = out_dir_q;
	assign result.sample_number = count_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !sample.ready)
		else $error("sample accepted while sequencer busy");

	a_no_line_no_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.line_present |-> !result.corner_found
			&& result.corner_direction == 2'sd0)
		else $error("corner flagged without a line");

	a_corner_direction: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.corner_found |-> result.corner_direction != 2'sd0)
		else $error("corner found without a direction");
`endif

endmodule
